// ===== sv/sph_pkg.sv =====
// shared types, codes and helpers for the sensor port handshake controller
package sph_pkg;

	// sizes
	localparam int PORTS   = 4;
	localparam int MODES   = 8;
	localparam int TIMER_W = 16;
	localparam int PORT_W  = $clog2(PORTS);
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// port state codes
	localparam logic [2:0] ST_OFF    = 3'd0;
	localparam logic [2:0] ST_BOOT   = 3'd1;
	localparam logic [2:0] ST_SWITCH = 3'd2;
	localparam logic [2:0] ST_SETTLE = 3'd3;
	localparam logic [2:0] ST_READY  = 3'd4;
	localparam logic [2:0] ST_TERM   = 3'd5;
	localparam logic [2:0] ST_WRITE  = 3'd6;

	// event codes
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_START  = 3'd1;
	localparam logic [2:0] ACT_STOP   = 3'd2;
	localparam logic [2:0] ACT_SWITCH = 3'd3;
	localparam logic [2:0] ACT_CMD    = 3'd4;

	// device classes
	localparam logic [1:0] CLS_NONE     = 2'd0;
	localparam logic [1:0] CLS_TERMINAL = 2'd1;
	localparam logic [1:0] CLS_SENSOR   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HS_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SW_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_SETTLE  = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] HS_TIMEOUT_RST = 16'd1000;
	localparam logic [CFG_W-1:0] SW_TIMEOUT_RST = 16'd100;
	localparam logic [CFG_W-1:0] DEF_SETTLE_RST = 16'd10;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  port;
		logic        link_is_serial;
		logic        pnp_change;
		logic        data_ready;
		logic        sending;
		logic [1:0]  probed_class;
		logic [2:0]  requested_mode;
		logic [15:0] settle_time;
	} item_t;

	typedef struct packed {
		logic [2:0]         state_code;
		logic [TIMER_W-1:0] countdown;
		logic               booting_mark;
		logic [2:0]         mode_sel;
		logic [1:0]         class_sel;
	} port_rec_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] port_state;
		logic       is_present;
		logic       is_ready;
		logic       handshake_done;
		logic       handshake_failed;
		logic [1:0] reported_class;
		logic [2:0] current_mode;
		logic       reload_request;
		logic       datalog_reset;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] handshake_timeout;
		logic [CFG_W-1:0] switch_timeout;
		logic [CFG_W-1:0] default_settle;
	} cfg_t;

	// bank write request from the update logic
	typedef struct packed {
		logic              we;
		logic [PORT_W-1:0] idx;
		port_rec_t         rec;
	} bank_wr_t;

	// timer load, saturating at the timer range
	function automatic logic [TIMER_W-1:0] timer_load(input logic [CFG_W-1:0] v);
		logic [CFG_W+TIMER_W-1:0] wide;
		logic [CFG_W+TIMER_W-1:0] tmax;
		wide = (CFG_W+TIMER_W)'(v);
		tmax = (CFG_W+TIMER_W)'({TIMER_W{1'b1}});
		return (wide > tmax) ? {TIMER_W{1'b1}} : wide[TIMER_W-1:0];
	endfunction

	function automatic logic present_state(input logic [2:0] s);
		return (s == ST_READY) || (s == ST_SWITCH) || (s == ST_SETTLE) || (s == ST_WRITE);
	endfunction

endpackage

// ===== sv/sph_chan_if.sv =====
// valid/ready channel interfaces for event items and result items

interface sph_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [1:0]  port;
	logic        link_is_serial;
	logic        pnp_change;
	logic        data_ready;
	logic        sending;
	logic [1:0]  probed_class;
	logic [2:0]  requested_mode;
	logic [15:0] settle_time;

	modport source (
		output valid, action, port, link_is_serial, pnp_change, data_ready, sending,
		output probed_class, requested_mode, settle_time,
		input  ready
	);
	modport sink (
		input  valid, action, port, link_is_serial, pnp_change, data_ready, sending,
		input  probed_class, requested_mode, settle_time,
		output ready
	);
endinterface

interface sph_res_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [2:0] port_state;
	logic       is_present;
	logic       is_ready;
	logic       handshake_done;
	logic       handshake_failed;
	logic [1:0] reported_class;
	logic [2:0] current_mode;
	logic       reload_request;
	logic       datalog_reset;

	modport source (
		output valid, accepted, port_state, is_present, is_ready, handshake_done,
		output handshake_failed, reported_class, current_mode, reload_request, datalog_reset,
		input  ready
	);
	modport sink (
		input  valid, accepted, port_state, is_present, is_ready, handshake_done,
		input  handshake_failed, reported_class, current_mode, reload_request, datalog_reset,
		output ready
	);
endinterface

// ===== sv/sph_state_bank.sv =====
// per-port state registers with one read port and one write port
module sph_state_bank (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sph_pkg::PORT_W-1:0]      rd_idx,
	output sph_pkg::port_rec_t              rd_rec,
	input  sph_pkg::bank_wr_t               wr
);

	sph_pkg::port_rec_t rec_q [sph_pkg::PORTS];

	// state update, all ports off at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sph_pkg::PORTS; i++) begin
				rec_q[i] <= '0;
			end
		end else if (wr.we) begin
			rec_q[wr.idx] <= wr.rec;
		end
	end

	assign rd_rec = rec_q[rd_idx];

endmodule

// ===== sv/sph_update.sv =====
// next-state and result logic for one event on one port
module sph_update (
	input  sph_pkg::item_t     item,
	input  sph_pkg::port_rec_t cur,
	input  sph_pkg::cfg_t      cfg,
	output sph_pkg::port_rec_t nxt,
	output sph_pkg::result_t   res,
	output logic               port_ok
);

	logic acc, done, failed, reload, dlreset;
	logic expire;
	logic [sph_pkg::TIMER_W-1:0] cd_dec;
	logic [sph_pkg::CFG_W-1:0]   settle_val;
	logic mode_ok;

	// countdown expires at zero or one
	assign expire     = cur.countdown <= sph_pkg::TIMER_W'(1);
	assign cd_dec     = expire ? '0 : cur.countdown - sph_pkg::TIMER_W'(1);
	assign settle_val = (item.settle_time != '0) ? item.settle_time : cfg.default_settle;
	assign mode_ok    = 32'(item.requested_mode) < 32'(sph_pkg::MODES);
	assign port_ok    = 32'(item.port) < 32'(sph_pkg::PORTS);

	// event handling
	always_comb begin
		nxt     = cur;
		acc     = 1'b0;
		done    = 1'b0;
		failed  = 1'b0;
		reload  = 1'b0;
		dlreset = 1'b0;
		unique case (item.action)
			sph_pkg::ACT_TICK: begin
				unique case (cur.state_code)
					sph_pkg::ST_BOOT: begin
						if (item.pnp_change || item.data_ready) begin
							if (item.probed_class == sph_pkg::CLS_TERMINAL) begin
								nxt.class_sel  = sph_pkg::CLS_TERMINAL;
								nxt.state_code = sph_pkg::ST_TERM;
								done           = 1'b1;
							end else if (item.probed_class == sph_pkg::CLS_SENSOR) begin
								nxt.class_sel  = sph_pkg::CLS_SENSOR;
								nxt.state_code = sph_pkg::ST_SWITCH;
								nxt.countdown  = sph_pkg::timer_load(cfg.switch_timeout);
							end else begin
								nxt.class_sel  = sph_pkg::CLS_NONE;
								nxt.state_code = sph_pkg::ST_OFF;
								failed         = 1'b1;
							end
						end else begin
							nxt.countdown = cd_dec;
							if (expire) begin
								nxt.state_code = sph_pkg::ST_OFF;
								failed         = 1'b1;
							end
						end
					end
					sph_pkg::ST_SWITCH: begin
						if (item.pnp_change) begin
							nxt.state_code = sph_pkg::ST_BOOT;
							nxt.countdown  = sph_pkg::timer_load(cfg.handshake_timeout);
							nxt.mode_sel   = '0;
						end else if (item.data_ready) begin
							nxt.state_code = sph_pkg::ST_SETTLE;
							nxt.countdown  = sph_pkg::timer_load(settle_val);
						end else begin
							nxt.countdown = cd_dec;
							if (expire) begin
								nxt.state_code = sph_pkg::ST_OFF;
								failed         = 1'b1;
							end
						end
					end
					sph_pkg::ST_SETTLE: begin
						if (item.pnp_change) begin
							nxt.state_code = sph_pkg::ST_BOOT;
							nxt.countdown  = sph_pkg::timer_load(cfg.handshake_timeout);
							nxt.mode_sel   = '0;
						end else begin
							nxt.countdown = cd_dec;
							if (expire) begin
								nxt.state_code = sph_pkg::ST_READY;
								dlreset        = 1'b1;
								if (cur.booting_mark) begin
									nxt.booting_mark = 1'b0;
									done             = 1'b1;
								end
							end
						end
					end
					sph_pkg::ST_READY: begin
						if (item.pnp_change) begin
							nxt.state_code = sph_pkg::ST_BOOT;
							nxt.countdown  = sph_pkg::timer_load(cfg.handshake_timeout);
							nxt.mode_sel   = '0;
						end
					end
					sph_pkg::ST_WRITE: begin
						if (item.pnp_change) begin
							nxt.state_code = sph_pkg::ST_BOOT;
							nxt.countdown  = sph_pkg::timer_load(cfg.handshake_timeout);
							nxt.mode_sel   = '0;
						end else if (!item.sending) begin
							nxt.state_code = sph_pkg::ST_READY;
						end
					end
					default: begin
					end
				endcase
			end
			sph_pkg::ACT_START: begin
				if (item.link_is_serial) begin
					nxt.class_sel    = sph_pkg::CLS_NONE;
					nxt.mode_sel     = '0;
					nxt.booting_mark = 1'b1;
					nxt.state_code   = sph_pkg::ST_BOOT;
					nxt.countdown    = sph_pkg::timer_load(cfg.handshake_timeout);
					reload           = 1'b1;
					acc              = 1'b1;
				end
			end
			sph_pkg::ACT_STOP: begin
				nxt.class_sel    = sph_pkg::CLS_NONE;
				nxt.mode_sel     = '0;
				nxt.booting_mark = 1'b0;
				nxt.state_code   = sph_pkg::ST_OFF;
				reload           = 1'b1;
			end
			sph_pkg::ACT_SWITCH: begin
				if (sph_pkg::present_state(cur.state_code) && mode_ok) begin
					acc = 1'b1;
					if (cur.mode_sel != item.requested_mode) begin
						nxt.mode_sel   = item.requested_mode;
						nxt.state_code = sph_pkg::ST_SWITCH;
						nxt.countdown  = sph_pkg::timer_load(cfg.switch_timeout);
						reload         = 1'b1;
					end
				end
			end
			sph_pkg::ACT_CMD: begin
				if (cur.state_code == sph_pkg::ST_READY) begin
					nxt.state_code = sph_pkg::ST_WRITE;
					acc            = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields, all zero for a port out of range
	always_comb begin
		res = '0;
		if (port_ok) begin
			res.accepted         = acc;
			res.port_state       = nxt.state_code;
			res.is_present       = sph_pkg::present_state(nxt.state_code);
			res.is_ready         = nxt.state_code == sph_pkg::ST_READY;
			res.handshake_done   = done;
			res.handshake_failed = failed;
			res.reported_class   = nxt.class_sel;
			res.current_mode     = nxt.mode_sel;
			res.reload_request   = reload;
			res.datalog_reset    = dlreset;
		end
	end

endmodule

// ===== sv/sensor_port_handshake_fsm_core.sv =====
// top level of the sensor port handshake controller
// Handshake controller for four smart-sensor serial ports.
// Channel evt carries one event per item (tick with line flags, start, stop,
// mode switch or command start) for one port; channel res returns exactly one
// result item per event with the port's new state and the pulse flags.
// Both channels use valid/ready; an item moves when both are high.
// An accepted event sits in the input register, is processed and loaded
// into the result register, which offers its result on res.
// Throughput: one event per cycle while res does not stall; the per-port
// state is written at the same edge that loads the result, so back-to-back
// events on one port see each other's effect. The state bank read and update
// logic set this figure.
// If res stalls, the result is held and one more event waits in the input
// register; evt.ready drops only when both are full.
// Configuration: cfg_we with cfg_index 0 handshake timeout, 1 switch timeout,
// 2 default settle; write only while no event is in flight.
// Reset (arst_n low): all ports off, counters and marks cleared, timeouts
// back to 1000, 100 and 10 ticks, both channels empty.
module sensor_port_handshake_fsm_core (
	input  logic                              clk,
	input  logic                              arst_n,
	sph_evt_if.sink                           evt,
	sph_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [sph_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sph_pkg::CFG_W-1:0]         cfg_wdata
);

	sph_pkg::cfg_t      cfg_q;
	sph_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               out_valid_q;
	sph_pkg::result_t   res_q;
	sph_pkg::port_rec_t cur_rec;
	sph_pkg::port_rec_t nxt_rec;
	sph_pkg::result_t   res_d;
	sph_pkg::bank_wr_t  bank_wr;
	logic               port_ok;
	logic               go_s1;
	logic               take_in;

	// handshake control
	assign go_s1     = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || go_s1;
	assign take_in   = evt.valid && evt.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handshake_timeout <= sph_pkg::HS_TIMEOUT_RST;
			cfg_q.switch_timeout    <= sph_pkg::SW_TIMEOUT_RST;
			cfg_q.default_settle    <= sph_pkg::DEF_SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sph_pkg::REG_HS_TIMEOUT: cfg_q.handshake_timeout <= cfg_wdata;
				sph_pkg::REG_SW_TIMEOUT: cfg_q.switch_timeout    <= cfg_wdata;
				sph_pkg::REG_DEF_SETTLE: cfg_q.default_settle    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.action         <= evt.action;
			item_s1.port           <= evt.port;
			item_s1.link_is_serial <= evt.link_is_serial;
			item_s1.pnp_change     <= evt.pnp_change;
			item_s1.data_ready     <= evt.data_ready;
			item_s1.sending        <= evt.sending;
			item_s1.probed_class   <= evt.probed_class;
			item_s1.requested_mode <= evt.requested_mode;
			item_s1.settle_time    <= evt.settle_time;
		end
	end

	sph_state_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (item_s1.port[sph_pkg::PORT_W-1:0]),
		.rd_rec (cur_rec),
		.wr     (bank_wr)
	);

	sph_update u_update (
		.item    (item_s1),
		.cur     (cur_rec),
		.cfg     (cfg_q),
		.nxt     (nxt_rec),
		.res     (res_d),
		.port_ok (port_ok)
	);

	// write back when the event moves into the result register
	assign bank_wr.we  = go_s1 && port_ok;
	assign bank_wr.idx = item_s1.port[sph_pkg::PORT_W-1:0];
	assign bank_wr.rec = nxt_rec;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (go_s1) begin
			res_q <= res_d;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.accepted         = res_q.accepted;
	assign res.port_state       = res_q.port_state;
	assign res.is_present       = res_q.is_present;
	assign res.is_ready         = res_q.is_ready;
	assign res.handshake_done   = res_q.handshake_done;
	assign res.handshake_failed = res_q.handshake_failed;
	assign res.reported_class   = res_q.reported_class;
	assign res.current_mode     = res_q.current_mode;
	assign res.reload_request   = res_q.reload_request;
	assign res.datalog_reset    = res_q.datalog_reset;

	// done and failed never fire on the same event
	a_done_failed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.handshake_done && res_q.handshake_failed))
		else $error("done and failed both set");

	// ready flag agrees with the reported state
	a_ready_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.is_ready == (res_q.port_state == sph_pkg::ST_READY)))
		else $error("is_ready inconsistent with port_state");

	// datalog reset only when the port lands in ready
	a_dlreset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.datalog_reset) |-> res_q.is_ready)
		else $error("datalog reset without ready state");

	// an accepted request never reports a failure
	a_acc_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.accepted) |-> !res_q.handshake_failed)
		else $error("accepted event reported failure");

	// a stalled result keeps the next event in the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready && valid_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost an event under stall");

endmodule
